FILE: rtl/core/ssum_pkg.sv
// Shared constants and the queue entry type of the subset-sum solver.
package ssum_pkg;

  localparam int MAX_ITEMS = 32;
  localparam int MAX_SUM = 255;

  localparam int VALUE_W = 8;
  localparam int TARGET_W = 8;
  localparam int INDEX_W = 6;
  localparam int REACH_W = MAX_SUM + 1;
  localparam int SUM_W = (MAX_SUM > 0) ? $clog2(MAX_SUM + 1) : 1;
  localparam int COUNT_W = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int REG_SEL_W = PADDR_W - 2;
  localparam logic [REG_SEL_W-1:0] REG_TARGET_SUM = REG_SEL_W'(0);

  typedef logic [REACH_W-1:0] reach_t;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               store;
    logic [COUNT_W-1:0] count;
    logic               ovf;
  } item_t;

endpackage

FILE: rtl/core/subset_sum_solver_unit.sv
// Top level of the subset-sum solver: configuration port and part wiring.
// Flow: an item beat enters the queue at acceptance and is folded into the reachable-sum
// vector when the idle back part pops it; after the last beat a report without traceback is
// loaded into the result register, or the traceback starts with a row read and an evaluation.
// Throughput: one item per cycle while the back part is idle and the queue has room; the
// traceback visits each item in a read state and then an evaluate state, bounded by the row store read port.
// Reset clears control state, the target register and the vector to sum zero, not the stores.
module subset_sum_solver_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssum_pkg::PADDR_W-1:0]  paddr,
  input  logic [ssum_pkg::PDATA_W-1:0]  pwdata,
  output logic [ssum_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ssum_pkg::VALUE_W-1:0]  item_value,
  input  logic                          last_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          found,
  output logic                          has_item,
  output logic [ssum_pkg::INDEX_W-1:0]  item_index,
  output logic [ssum_pkg::VALUE_W-1:0]  chosen_value,
  output logic                          overflow,
  output logic                          last_result
);

  logic [ssum_pkg::TARGET_W-1:0]  target_sum;
  logic [ssum_pkg::REG_SEL_W-1:0] reg_sel;
  logic                           cfg_write;

  logic                           push;
  logic                           pop;
  logic                           q_empty;
  logic                           q_full;
  ssum_pkg::item_t                push_entry;
  ssum_pkg::item_t                head;

  // Registers sit on 32-bit word boundaries; the low address bits are ignored.
  assign pready = 1'b1;
  assign reg_sel = paddr[ssum_pkg::PADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (reg_sel == ssum_pkg::REG_TARGET_SUM) begin
      prdata = ssum_pkg::PDATA_W'(target_sum);
    end
  end

  // The user must write the target only while no list is in flight; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
    end else if (cfg_write && (reg_sel == ssum_pkg::REG_TARGET_SUM)) begin
      target_sum <= pwdata[ssum_pkg::TARGET_W-1:0];
    end
  end

  // The front counts beats and marks overflow, so it never waits on the back
  // part unless the queue between them is full.
  ssum_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .item_value (item_value),
    .last_item  (last_item),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  ssum_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  // The back part holds the result register, so a stalled result beat does not
  // stop the front from taking further items into the queue until it is full.
  ssum_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (pop),
    .target_sum   (target_sum),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .has_item     (has_item),
    .item_index   (item_index),
    .chosen_value (chosen_value),
    .overflow     (overflow),
    .last_result  (last_result)
  );

endmodule

FILE: rtl/core/ssum_front.sv
// Front part: accepts item beats, counts them and classifies each one.
module ssum_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ssum_pkg::VALUE_W-1:0] item_value,
  input  logic                        last_item,
  input  logic                        q_full,
  output logic                        push,
  output ssum_pkg::item_t             push_entry
);

  logic [ssum_pkg::COUNT_W-1:0] item_count;
  logic                         overflow_seen;
  logic                         store;

  assign in_stall = q_full;
  assign push = in_valid && !q_full;
  assign store = (int'(item_count) < ssum_pkg::MAX_ITEMS);

  always_comb begin
    push_entry.value = item_value;
    push_entry.last = last_item;
    push_entry.store = store;
    push_entry.count = store ? item_count + ssum_pkg::COUNT_W'(1) : item_count;
    push_entry.ovf = overflow_seen || !store;
  end

  // A last beat closes the list, so the count starts again for the next one.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= '0;
      overflow_seen <= 1'b0;
    end else if (push) begin
      if (last_item) begin
        item_count <= '0;
        overflow_seen <= 1'b0;
      end else begin
        item_count <= push_entry.count;
        overflow_seen <= push_entry.ovf;
      end
    end
  end

endmodule

FILE: rtl/core/ssum_queue.sv
// Short first-in first-out queue between the front and the back parts.
module ssum_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ssum_pkg::item_t push_entry,
  input  logic            pop,
  output ssum_pkg::item_t head,
  output logic            empty,
  output logic            full
);

  ssum_pkg::item_t                entries [ssum_pkg::QUEUE_DEPTH];
  logic [ssum_pkg::QPTR_W-1:0]    wr_ptr;
  logic [ssum_pkg::QPTR_W-1:0]    rd_ptr;
  logic [ssum_pkg::QPTR_W:0]      fill;

  assign empty = (fill == '0);
  assign full = (int'(fill) == ssum_pkg::QUEUE_DEPTH);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + ssum_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + ssum_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (ssum_pkg::QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (ssum_pkg::QPTR_W + 1)'(1);
      end
    end
  end

endmodule

FILE: rtl/core/ssum_back.sv
// Back part: reachable-sum update, row store, target check and traceback.
module ssum_back (
  input  logic                          clk,
  input  logic                          rst,
  input  ssum_pkg::item_t               head,
  input  logic                          q_empty,
  output logic                          pop,
  input  logic [ssum_pkg::TARGET_W-1:0] target_sum,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          found,
  output logic                          has_item,
  output logic [ssum_pkg::INDEX_W-1:0]  item_index,
  output logic [ssum_pkg::VALUE_W-1:0]  chosen_value,
  output logic                          overflow,
  output logic                          last_result
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SINGLE = 4'b0010,
    S_READ   = 4'b0100,
    S_EVAL   = 4'b1000
  } back_state_t;

  localparam ssum_pkg::reach_t REACH_INIT = ssum_pkg::reach_t'(1);
  localparam int DIFF_W = ssum_pkg::TARGET_W + 1;

  function automatic logic reach_bit(input ssum_pkg::reach_t row,
                                     input logic [DIFF_W-1:0] sum);
    logic hit;
    hit = 1'b0;
    if (int'(sum) <= ssum_pkg::MAX_SUM) begin
      hit = row[ssum_pkg::SUM_W'(sum)];
    end
    return hit;
  endfunction

  back_state_t state, state_next;

  ssum_pkg::reach_t cur_reach;
  ssum_pkg::reach_t reach_after;

  // Row and value stores, one write port and one registered read port each.
  ssum_pkg::reach_t                 rows [ssum_pkg::MAX_ITEMS];
  logic [ssum_pkg::VALUE_W-1:0]     vals [ssum_pkg::MAX_ITEMS];
  ssum_pkg::reach_t                 row_q;
  logic [ssum_pkg::VALUE_W-1:0]     val_q;
  logic                             row_first;

  logic [ssum_pkg::COUNT_W-1:0]     tb_i;
  logic [ssum_pkg::TARGET_W-1:0]    tb_j;
  logic                             ovf_r;
  logic                             hit_r;

  logic                             row_we;
  logic                             rd_en;
  logic [ssum_pkg::IDX_W-1:0]       wr_addr;
  logic [ssum_pkg::IDX_W-1:0]       row_raddr;
  logic [ssum_pkg::IDX_W-1:0]       val_raddr;
  logic                             start_hit;

  logic [DIFF_W-1:0]                diff;
  logic [ssum_pkg::TARGET_W-1:0]    new_j;
  logic                             take;
  logic                             step;
  logic                             out_free;
  logic                             out_load;
  logic                             o_found;
  logic                             o_has_item;
  logic [ssum_pkg::INDEX_W-1:0]     o_index;
  logic [ssum_pkg::VALUE_W-1:0]     o_value;
  logic                             o_last;

  assign reach_after = head.store ? (cur_reach | (cur_reach << head.value)) : cur_reach;
  assign start_hit = reach_bit(reach_after, {1'b0, target_sum});
  assign wr_addr = ssum_pkg::IDX_W'(head.count - ssum_pkg::COUNT_W'(1));
  assign val_raddr = ssum_pkg::IDX_W'(tb_i - ssum_pkg::COUNT_W'(1));
  assign row_raddr = ssum_pkg::IDX_W'(tb_i - ssum_pkg::COUNT_W'(2));

  // The item is taken when the remainder was reachable with the items before it.
  assign diff = {1'b0, tb_j} - DIFF_W'(val_q);
  assign new_j = diff[ssum_pkg::TARGET_W-1:0];
  assign take = !diff[DIFF_W-1] && (row_first ? (diff == '0) : reach_bit(row_q, diff));
  assign out_free = !out_valid || !out_stall;
  assign step = (state == S_EVAL) && (!take || out_free);

  always_comb begin
    state_next = state;
    pop = 1'b0;
    row_we = 1'b0;
    rd_en = 1'b0;
    out_load = 1'b0;
    o_found = 1'b0;
    o_has_item = 1'b0;
    o_index = '0;
    o_value = '0;
    o_last = 1'b0;
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          row_we = head.store;
          if (head.last) begin
            if (!start_hit || (target_sum == '0)) begin
              state_next = S_SINGLE;
            end else begin
              state_next = S_READ;
            end
          end
        end
      end
      S_SINGLE: begin
        if (out_free) begin
          out_load = 1'b1;
          o_found = hit_r;
          o_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        rd_en = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (take) begin
          if (out_free) begin
            out_load = 1'b1;
            o_found = 1'b1;
            o_has_item = 1'b1;
            o_index = ssum_pkg::INDEX_W'(tb_i);
            o_value = val_q;
            o_last = (new_j == '0);
            if ((new_j == '0) || (tb_i == ssum_pkg::COUNT_W'(1))) begin
              state_next = S_IDLE;
            end else begin
              state_next = S_READ;
            end
          end
        end else if (tb_i == ssum_pkg::COUNT_W'(1)) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur_reach <= REACH_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) begin
        cur_reach <= head.last ? REACH_INIT : reach_after;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      rows[wr_addr] <= reach_after;
      vals[wr_addr] <= head.value;
    end
    if (rd_en) begin
      row_q <= rows[row_raddr];
      val_q <= vals[val_raddr];
      row_first <= (tb_i == ssum_pkg::COUNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      ovf_r <= head.ovf;
      hit_r <= start_hit;
      tb_i <= head.count;
      tb_j <= target_sum;
    end else if (step) begin
      tb_i <= tb_i - ssum_pkg::COUNT_W'(1);
      if (take) begin
        tb_j <= new_j;
      end
    end
    if (out_load) begin
      found <= o_found;
      has_item <= o_has_item;
      item_index <= o_index;
      chosen_value <= o_value;
      overflow <= ovf_r;
      last_result <= o_last;
    end
  end

  // A taken item waits for the output register rather than being dropped.
  a_eval_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) && take && out_valid && out_stall |=> (state == S_EVAL))
    else $error("traceback advanced while its result had no room");

  // The traceback never reads past the first item.
  a_read_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (tb_i != '0))
    else $error("traceback read with no item left");

  // A final traceback result returns the back part to idle.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_load && o_last |=> (state == S_IDLE))
    else $error("report continued after its final result");

  // A result that names an item carries a one-based index.
  a_index_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_item |-> (item_index != '0) && found)
    else $error("chosen item without a valid index");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the subset-sum solver with its own reachable-sum predictor.
`timescale 1ns / 100ps

module testbench;
  import ssum_pkg::*;

  // Roughly how many random item beats are planned after the directed lists.
  localparam int RANDOM_ITEMS = 480;
  // A traceback visits at most MAX_ITEMS rows, each with a read and an evaluate step, so this pause
  // is enough for the block to fall idle once the last report has come out.
  localparam int SETTLE_CYCLES = 2 * MAX_ITEMS + 8;
  // Consecutive cycles with no beat moving on either channel before we give up.
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [VALUE_W-1:0] val;
    logic               last;
  } item_beat_t;

  // One report beat as the block should present it.
  typedef struct packed {
    logic               found;
    logic               has_item;
    logic [INDEX_W-1:0] pos;
    logic [VALUE_W-1:0] val;
    logic               overflow;
    logic               last;
  } pick_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [VALUE_W-1:0]  item_value = '0;
  logic                last_item = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                found;
  logic                has_item;
  logic [INDEX_W-1:0]  item_index;
  logic [VALUE_W-1:0]  chosen_value;
  logic                overflow;
  logic                last_result;

  subset_sum_solver_unit DUT (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the block's rows, values and counters.
  // ---------------------------------------------------------------------------
  reach_t             sum_rows [MAX_ITEMS];
  logic [VALUE_W-1:0] item_vals [MAX_ITEMS];
  reach_t             live_sums = reach_t'(1);
  int unsigned        n_items = 0;
  logic               ovf_seen = 1'b0;
  logic [VALUE_W-1:0] goal_sum = '0;

  item_beat_t  item_backlog [$];
  pick_t       picks_due [$];
  int unsigned items_planned = 0;
  int          fault_count = 0;
  int          quiet_cycles = 0;

  // Idling controls, changed by the sequence between phases.
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int in_gap = 0;
  int stall_left = 0;

  item_beat_t driven_beat;
  pick_t      seen_pick;
  pick_t      want_pick;

  function automatic void flag_fault(string msg);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic void log_pick(logic f, logic h, logic [INDEX_W-1:0] p,
                                   logic [VALUE_W-1:0] v, logic l);
    picks_due.push_back('{found: f, has_item: h, pos: p, val: v, overflow: ovf_seen,
                          last: l});
  endfunction

  // Whether sum j can be made from the first i items of the current list.
  // Row zero is the empty subset, which reaches only sum zero.
  function automatic logic sum_reachable(int unsigned i, int unsigned j);
    if (j > MAX_SUM) begin
      return 1'b0;
    end
    if (i == 0) begin
      return j == 0;
    end
    return sum_rows[i-1][j];
  endfunction

  // Folds one accepted item into the reachable-sum vector and, on the last
  // item of a list, queues the report the block should produce for it.
  function automatic void fold_item(logic [VALUE_W-1:0] v, logic is_last);
    int unsigned        row;
    int unsigned        rest;
    int unsigned        taken;
    logic [VALUE_W-1:0] a;
    if (n_items < MAX_ITEMS) begin
      item_vals[n_items] = v;
      // The vector is exactly MAX_SUM+1 bits wide, so sums beyond it fall off.
      live_sums = live_sums | (live_sums << v);
      sum_rows[n_items] = live_sums;
      n_items++;
    end else begin
      ovf_seen = 1'b1;
    end
    if (!is_last) begin
      return;
    end
    if (!sum_reachable(n_items, goal_sum)) begin
      log_pick(1'b0, 1'b0, '0, '0, 1'b1);
    end else if (goal_sum == 0) begin
      log_pick(1'b1, 1'b0, '0, '0, 1'b1);
    end else begin
      // Walk back from the newest item, taking it whenever the remainder was
      // already reachable without it.
      row = n_items;
      rest = goal_sum;
      taken = 0;
      while (rest > 0 && row > 0 && taken < MAX_ITEMS) begin
        a = item_vals[row-1];
        if (rest >= a && sum_reachable(row - 1, rest - a)) begin
          rest -= a;
          log_pick(1'b1, 1'b1, INDEX_W'(row), a, rest == 0);
          taken++;
        end
        row--;
      end
    end
    live_sums = reach_t'(1);
    n_items = 0;
    ovf_seen = 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Item driver: presents beats from the backlog, predicts each one as it is
  // accepted, and inserts random gaps after some beats.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        fold_item(item_value, last_item);
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (item_backlog.size() != 0) begin
          driven_beat = item_backlog.pop_front();
          in_valid <= 1'b1;
          item_value <= driven_beat.val;
          last_item <= driven_beat.last;
          if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
            in_gap = $urandom_range(1, 13);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Back-pressure on the report channel, also in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(1, 13) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Report monitor: every accepted report beat is matched against the oldest
  // prediction still waiting.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_pick = '{found, has_item, item_index, chosen_value, overflow, last_result};
      if (picks_due.size() == 0) begin
        flag_fault($sformatf("report beat with nothing predicted: found=%0b item=%0b idx=%0d val=%0d ovf=%0b last=%0b",
                             found, has_item, item_index, chosen_value, overflow, last_result));
      end else begin
        want_pick = picks_due.pop_front();
        if (seen_pick !== want_pick) begin
          flag_fault($sformatf({"report mismatch: expected found=%0b item=%0b idx=%0d val=%0d ovf=%0b last=%0b,",
                                " got found=%0b item=%0b idx=%0d val=%0d ovf=%0b last=%0b"},
                               want_pick.found, want_pick.has_item, want_pick.pos, want_pick.val,
                               want_pick.overflow, want_pick.last, seen_pick.found,
                               seen_pick.has_item, seen_pick.pos, seen_pick.val,
                               seen_pick.overflow, seen_pick.last));
        end
      end
    end
  end

  // The watchdog only looks at cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("subset_sum_solver_unit test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic queue_beat(logic [VALUE_W-1:0] v, logic l);
    item_backlog.push_back('{val: v, last: l});
  endtask

  // Waits until every beat has gone in and every report has come out, then
  // gives the block time to finish any work that produces no report.
  task automatic settle_block();
    do @(negedge clk); while (item_backlog.size() != 0 || in_valid || picks_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes the target register over the configuration port once the block is idle.
  task automatic set_goal(logic [VALUE_W-1:0] goal);
    settle_block();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_TARGET_SUM, 2'b00};
    pwdata <= PDATA_W'(goal);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    goal_sum = goal;
    @(negedge clk);
  endtask

  // Mostly small values so that subsets collide often, with the full range mixed in.
  function automatic logic [VALUE_W-1:0] random_value();
    if ($urandom_range(0, 3) == 0) begin
      return VALUE_W'($urandom_range(0, 255));
    end
    return VALUE_W'($urandom_range(0, 40));
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0: begin
        return 0;
      end
      1: begin
        return 10;
      end
      2: begin
        return 30;
      end
      default: begin
        return 60;
      end
    endcase
  endfunction

  // Plans one list. Most lists hide a subset that sums to the goal among some
  // noise items; the rest are plain random, long, or longer than the store.
  task automatic plan_list(logic [VALUE_W-1:0] goal);
    logic [VALUE_W-1:0] vals [$];
    int unsigned        mode;
    int unsigned        parts;
    int unsigned        rest;
    int unsigned        part;
    int unsigned        extra;
    int unsigned        len;
    mode = $urandom_range(0, 19);
    if (mode < 12) begin
      parts = $urandom_range(1, 4);
      rest = goal;
      for (int p = 1; p < parts; p++) begin
        part = $urandom_range(0, rest);
        vals.push_back(VALUE_W'(part));
        rest -= part;
      end
      vals.push_back(VALUE_W'(rest));
      extra = $urandom_range(0, 6);
      for (int e = 0; e < extra; e++) begin
        vals.insert($urandom_range(0, vals.size()), random_value());
      end
    end else if (mode < 17) begin
      len = $urandom_range(1, 8);
      for (int e = 0; e < len; e++) begin
        vals.push_back(random_value());
      end
    end else if (mode < 19) begin
      len = $urandom_range(9, MAX_ITEMS);
      for (int e = 0; e < len; e++) begin
        vals.push_back(VALUE_W'($urandom_range(0, 15)));
      end
    end else begin
      // Past the store: the surplus items are dropped and flagged as overflow.
      len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
      for (int e = 0; e < len; e++) begin
        vals.push_back(random_value());
      end
    end
    foreach (vals[k]) begin
      queue_beat(vals[k], k == vals.size() - 1);
    end
    items_planned += vals.size();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned        phase;
    int unsigned        phase_start;
    logic [VALUE_W-1:0] goal;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    in_idle_pct = 20;
    out_idle_pct = 20;

    // A single item that hits the goal, one that misses it, and a list in
    // which zero-valued items are picked up on the way back.
    set_goal(8'd5);
    queue_beat(8'd5, 1'b1);
    queue_beat(8'd4, 1'b1);
    queue_beat(8'd2, 1'b0);
    queue_beat(8'd0, 1'b0);
    queue_beat(8'd3, 1'b1);

    // The largest goal: reached by one full-scale item, missed when the only
    // way to it would need a sum beyond the top of the vector, and reached by two.
    set_goal(8'd255);
    queue_beat(8'd255, 1'b1);
    queue_beat(8'd200, 1'b0);
    queue_beat(8'd100, 1'b1);
    queue_beat(8'd128, 1'b0);
    queue_beat(8'd127, 1'b1);

    // A zero goal is always met by the empty subset, whatever the list holds.
    set_goal(8'd0);
    queue_beat(8'd0, 1'b1);
    queue_beat(8'd255, 1'b1);
    queue_beat(8'd7, 1'b0);
    queue_beat(8'd9, 1'b1);

    // Every item is needed, so the traceback reports all of them.
    set_goal(8'd3);
    queue_beat(8'd1, 1'b0);
    queue_beat(8'd1, 1'b0);
    queue_beat(8'd1, 1'b1);

    // Random phases of about sixty items, each with its own goal and idling;
    // the closing stretch runs with no idling on either side.
    phase = 0;
    while (items_planned < RANDOM_ITEMS) begin
      if (phase == 0) begin
        goal = 8'd255;
      end else if (phase == 1) begin
        goal = 8'd0;
      end else if ($urandom_range(0, 3) == 0) begin
        goal = VALUE_W'($urandom_range(0, 255));
      end else begin
        goal = VALUE_W'($urandom_range(1, 60));
      end
      set_goal(goal);
      if (items_planned + 80 >= RANDOM_ITEMS) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct = pick_idle_pct();
        out_idle_pct = pick_idle_pct();
      end
      phase_start = items_planned;
      while (items_planned - phase_start < 60 && items_planned < RANDOM_ITEMS) begin
        plan_list(goal);
      end
      phase++;
    end

    settle_block();
    if (fault_count == 0) begin
      $display("subset_sum_solver_unit test passed");
    end else begin
      $display("subset_sum_solver_unit test failed");
    end
    $finish;
  end

endmodule

FILE: subset_sum_solver_unit.f
rtl/core/ssum_pkg.sv
rtl/core/ssum_front.sv
rtl/core/ssum_queue.sv
rtl/core/ssum_back.sv
rtl/core/subset_sum_solver_unit.sv
dv/testbench.sv
